@@ design/ncw_pkg.sv @@
// ----------------------------------------------------------------------------
// ncw_pkg - shared types and constants for the nearest color classifier
// Pixel and result item layouts, the color entry layout, register indexes and
// the per-channel window and distance helpers used by every cell.
// ----------------------------------------------------------------------------
package ncw_pkg;

  // table size and field widths
  localparam int NUM_COLORS_DEF = 7;
  localparam int IDX_W          = 3;
  localparam int CFG_DATA_W     = 48;
  localparam int ERR_W          = 10;

  // error ceiling: every qualifying color lies below it (max error is 765)
  localparam logic [ERR_W-1:0] ERR_CEILING = 10'd1000;

  // register indexes
  localparam logic [IDX_W-1:0] REG_COLOR_COUNT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_COLOR_ENTRY0 = 3'd1;

  // input item
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // result item
  typedef struct packed {
    logic             matched;
    logic [IDX_W-1:0] color_index;
  } res_t;

  // one reference color, bytes high to low
  typedef struct packed {
    logic [7:0] red_mean;
    logic [7:0] red_spread;
    logic [7:0] green_mean;
    logic [7:0] green_spread;
    logic [7:0] blue_mean;
    logic [7:0] blue_spread;
  } entry_t;

  // configuration write as seen by each cell
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // item moving down the chain with the best match so far
  typedef struct packed {
    logic             valid;
    pix_t             pix;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [ERR_W-1:0] best_err;
  } flit_t;

  // strict window test: mean - 2*spread < x < mean + 2*spread
  function automatic logic chan_ok(input logic [7:0] x, input logic [7:0] u,
                                   input logic [7:0] s);
    logic [9:0] x_w;
    logic [9:0] u_w;
    logic [9:0] s2_w;
    x_w  = {2'b00, x};
    u_w  = {2'b00, u};
    s2_w = {1'b0, s, 1'b0};
    return ((x_w + s2_w) > u_w) && (x_w < (u_w + s2_w));
  endfunction

  // absolute channel difference
  function automatic logic [7:0] abs_diff(input logic [7:0] x, input logic [7:0] u);
    return (u >= x) ? (u - x) : (x - u);
  endfunction

endpackage

@@ design/nearest_color_window_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// nearest_color_window_classifier_unit - nearest reference color classifier
// A pixel is tested against up to NUM_COLORS reference colors, each with a
// strict per-channel window of two spreads around its mean; the closest
// qualifying color by manhattan distance wins, the lower index on ties.
//
// Usage:
//   input channel: in_data carries red, green, blue; an item is taken at a
//     clock edge with start high and busy low. busy is always low, so one
//     pixel can be taken every cycle.
//   result channel: out_valid strobes for one cycle with out_data (matched,
//     color_index); color_index is 0 when nothing matched.
//   chain: an item passes one register in each cell of the chain; throughput
//     is one item per cycle.
//   configuration: cfg_we, cfg_index, cfg_wdata; index 0 is the color count,
//     indexes 1 to 7 the color entries; write only while the chain is empty.
//   reset: synchronous, clears the count, the entries and all items in flight.
//   the receiver cannot stall; every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module nearest_color_window_classifier_unit #(
  parameter int NUM_COLORS = ncw_pkg::NUM_COLORS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input items
  input  logic                           start,
  output logic                           busy,
  input  ncw_pkg::pix_t                  in_data,
  // result items
  output logic                           out_valid,
  output ncw_pkg::res_t                  out_data,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [ncw_pkg::IDX_W-1:0]      cfg_index,
  input  logic [ncw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [ncw_pkg::IDX_W-1:0] COUNT_MAX = ncw_pkg::IDX_W'(NUM_COLORS);

  logic [ncw_pkg::IDX_W-1:0] count_r;
  logic [ncw_pkg::IDX_W-1:0] count_sat;
  ncw_pkg::cfg_wr_t          cfg;
  ncw_pkg::flit_t            chain [0:NUM_COLORS];
  ncw_pkg::flit_t            last;

  // never holds off input items
  assign busy = 1'b0;

  // configuration bundle
  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  // color count register, saturated to the table size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we && cfg_index == ncw_pkg::REG_COLOR_COUNT) begin
      count_r <= cfg_wdata[ncw_pkg::IDX_W-1:0];
    end
  end

  assign count_sat = (count_r > COUNT_MAX) ? COUNT_MAX : count_r;

  // chain head: new item with no match yet
  always_comb begin
    chain[0].valid    = start && !busy;
    chain[0].pix      = in_data;
    chain[0].found    = 1'b0;
    chain[0].idx      = '0;
    chain[0].best_err = ncw_pkg::ERR_CEILING;
  end

  // row of color cells
  for (genvar k = 0; k < NUM_COLORS; k++) begin : g_cell
    ncw_cell #(
      .CELL_INDEX(k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg      (cfg),
      .count    (count_sat),
      .flit_in  (chain[k]),
      .flit_out (chain[k+1])
    );
  end

  // result from the last cell register
  assign last                 = chain[NUM_COLORS];
  assign out_valid            = last.valid;
  assign out_data.matched     = last.found;
  assign out_data.color_index = last.found ? last.idx : '0;

  // items advance one cell per cycle, none lost or invented
  for (genvar k = 0; k < NUM_COLORS; k++) begin : g_chk
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
      $past(rst_n) |-> chain[k+1].valid == $past(chain[k].valid))
      else $error("chain item lost or invented");
  end

  // a winning color always lies in the table
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.matched) |-> out_data.color_index < COUNT_MAX)
    else $error("winning index beyond table");

  // a match carries a real distance, below the ceiling
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && last.found) |-> last.best_err <= 10'd765)
    else $error("match with impossible distance");

  // no match leaves the ceiling untouched
  a_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !last.found) |-> last.best_err == ncw_pkg::ERR_CEILING)
    else $error("distance changed without a match");

endmodule

@@ design/ncw_cell.sv @@
// ----------------------------------------------------------------------------
// ncw_cell - one reference color of the classifier chain
// Holds one color entry, tests the passing pixel against its windows and
// takes over the running best match when its distance is strictly smaller.
// ----------------------------------------------------------------------------
module ncw_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ncw_pkg::cfg_wr_t          cfg,
  input  logic [ncw_pkg::IDX_W-1:0] count,
  input  ncw_pkg::flit_t            flit_in,
  output ncw_pkg::flit_t            flit_out
);

  localparam logic [ncw_pkg::IDX_W-1:0] MY_IDX = ncw_pkg::IDX_W'(CELL_INDEX);
  localparam logic [ncw_pkg::IDX_W-1:0] MY_REG =
    ncw_pkg::IDX_W'(ncw_pkg::REG_COLOR_ENTRY0 + ncw_pkg::IDX_W'(CELL_INDEX));

  ncw_pkg::entry_t           entry_r;
  ncw_pkg::flit_t            flit_r;
  ncw_pkg::flit_t            flit_nxt;
  logic                      enabled;
  logic                      in_win;
  logic [ncw_pkg::ERR_W-1:0] err;
  logic                      better;

  // color entry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else if (cfg.we && cfg.index == MY_REG) begin
      entry_r <= ncw_pkg::entry_t'(cfg.data);
    end
  end

  // window test and manhattan distance
  always_comb begin
    enabled = MY_IDX < count;
    in_win  = ncw_pkg::chan_ok(flit_in.pix.red,   entry_r.red_mean,   entry_r.red_spread)
           && ncw_pkg::chan_ok(flit_in.pix.green, entry_r.green_mean, entry_r.green_spread)
           && ncw_pkg::chan_ok(flit_in.pix.blue,  entry_r.blue_mean,  entry_r.blue_spread);
    err = ncw_pkg::ERR_W'(ncw_pkg::abs_diff(flit_in.pix.red,   entry_r.red_mean))
        + ncw_pkg::ERR_W'(ncw_pkg::abs_diff(flit_in.pix.green, entry_r.green_mean))
        + ncw_pkg::ERR_W'(ncw_pkg::abs_diff(flit_in.pix.blue,  entry_r.blue_mean));
    better = enabled && in_win && (err < flit_in.best_err);
  end

  // best match update
  always_comb begin
    flit_nxt = flit_in;
    if (better) begin
      flit_nxt.found    = 1'b1;
      flit_nxt.idx      = MY_IDX;
      flit_nxt.best_err = err;
    end
  end

  // stage register, only valid is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flit_r.valid <= 1'b0;
    end else begin
      flit_r.valid <= flit_nxt.valid;
    end
    flit_r.pix      <= flit_nxt.pix;
    flit_r.found    <= flit_nxt.found;
    flit_r.idx      <= flit_nxt.idx;
    flit_r.best_err <= flit_nxt.best_err;
  end

  assign flit_out = flit_r;

endmodule
